// ===== hw/rtl/lidar_height_gate_unit_assert.svh =====
// Assertion macros shared by the height gate checker.
`ifndef LIDAR_HEIGHT_GATE_UNIT_ASSERT_SVH
`define LIDAR_HEIGHT_GATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while rst_n is low.
`define LHG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rst_n is low.
`define LHG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lhg_pkg.sv =====
// Shared types, register codes and sine table builder for the lidar height gate.
package lhg_pkg;

    typedef enum logic [1:0] {
        REG_HEIGHT_LIMIT = 2'd0,
        REG_START_ANGLE  = 2'd1,
        REG_ANGLE_STEP   = 2'd2,
        REG_SIDE_SELECT  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [15:0]        height_limit_mm;
        logic [15:0]        start_angle;
        logic signed [15:0] angle_step;
        logic               side_select;
    } cfg_t;

    localparam logic [15:0] HEIGHT_LIMIT_RESET = 16'd1500;
    localparam logic [63:0] HALF_PI_Q30        = 64'd1686629713;
    localparam logic [63:0] SINE_ONE           = 64'd65536;

    // Taylor series of sin(x), x in Q30, result in Q16 clamped to one.
    function automatic logic [16:0] series_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum  = (sum >= term) ? sum - term : 64'd0;
        sum  = (sum + 64'd8192) >> 14;
        return (sum > SINE_ONE) ? SINE_ONE[16:0] : sum[16:0];
    endfunction

endpackage

// ===== hw/rtl/lhg_cfg.sv =====
// APB configuration registers of the lidar height gate.
module lhg_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output lhg_pkg::cfg_t      cfg
);
    import lhg_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t reg_sel;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_sel)
                REG_HEIGHT_LIMIT: cfg_next.height_limit_mm = pwdata[15:0];
                REG_START_ANGLE:  cfg_next.start_angle     = pwdata[15:0];
                REG_ANGLE_STEP:   cfg_next.angle_step      = pwdata[15:0];
                REG_SIDE_SELECT:  cfg_next.side_select     = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_HEIGHT_LIMIT: prdata = {16'd0, cfg_reg.height_limit_mm};
            REG_START_ANGLE:  prdata = {16'd0, cfg_reg.start_angle};
            REG_ANGLE_STEP:   prdata = {16'd0, cfg_reg.angle_step};
            REG_SIDE_SELECT:  prdata = {31'd0, cfg_reg.side_select};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.height_limit_mm <= HEIGHT_LIMIT_RESET;
            cfg_reg.start_angle     <= 16'd0;
            cfg_reg.angle_step      <= 16'sd0;
            cfg_reg.side_select     <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/lhg_front.sv =====
// Front end: accept samples, track the beam angle, classify and fold to a table index.
module lhg_front #(
    parameter int ANGLE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  lhg_pkg::cfg_t                         cfg,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [15:0]                           s_tdata,
    input  logic [1:0]                            s_tuser,
    input  logic                                  q_full,
    output logic                                  push,
    output logic [15:0]                           q_range,
    output logic                                  q_ok,
    output logic                                  q_check,
    output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] q_idx,
    output logic [15:0]                           q_angle
);
    import lhg_pkg::*;

    localparam int IdxBits   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int FoldShift = ANGLE_BITS - 2;
    localparam int ProdBits  = ANGLE_BITS - 1 + IdxBits;
    localparam logic [ANGLE_BITS-1:0] HalfTurn    = {1'b1, {(ANGLE_BITS-1){1'b0}}};
    localparam logic [ANGLE_BITS-2:0] QuarterTurn = {1'b1, {FoldShift{1'b0}}};
    localparam logic [FoldShift-1:0]  HalfQuarter = {1'b1, {(FoldShift-1){1'b0}}};

    logic [ANGLE_BITS-1:0] acc_reg;
    logic [ANGLE_BITS-1:0] acc_next;
    logic [ANGLE_BITS-1:0] start_w;
    logic [ANGLE_BITS-1:0] step_w;
    logic [ANGLE_BITS-1:0] angle;
    logic [ANGLE_BITS-2:0] p_half;
    logic [ANGLE_BITS-1:0] p_mirror;
    logic [ANGLE_BITS-2:0] p_fold;
    logic [ProdBits-1:0]   idx_prod;
    logic [ProdBits-1:0]   idx_full;
    logic                  checked;
    logic                  accept;

    generate
        if (ANGLE_BITS >= 16) begin : g_wide
            assign start_w = ANGLE_BITS'(cfg.start_angle) << (ANGLE_BITS - 16);
            assign step_w  = ANGLE_BITS'(cfg.angle_step) << (ANGLE_BITS - 16);
            assign q_angle = 16'(angle >> (ANGLE_BITS - 16));
        end else begin : g_narrow
            assign start_w = ANGLE_BITS'(cfg.start_angle >> (16 - ANGLE_BITS));
            assign step_w  = ANGLE_BITS'(cfg.angle_step >>> (16 - ANGLE_BITS));
            assign q_angle = 16'(angle) << (16 - ANGLE_BITS);
        end
    endgenerate

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept;

    assign angle    = s_tuser[1] ? start_w : acc_reg;
    assign acc_next = accept ? angle + step_w : acc_reg;

    assign checked  = cfg.side_select ? (angle[ANGLE_BITS-1] && (|angle[ANGLE_BITS-2:0]))
                                      : !angle[ANGLE_BITS-1];

    // fold the half-turn offset into the first quarter
    assign p_half   = angle[ANGLE_BITS-2:0];
    assign p_mirror = HalfTurn - {1'b0, p_half};
    assign p_fold   = (p_half > QuarterTurn) ? p_mirror[ANGLE_BITS-2:0] : p_half;

    // round half up to the nearest table step
    assign idx_prod = ProdBits'(p_fold) * ProdBits'(SINE_TABLE_DEPTH) + ProdBits'(HalfQuarter);
    assign idx_full = idx_prod >> FoldShift;
    assign q_idx    = (idx_full > ProdBits'(SINE_TABLE_DEPTH)) ? IdxBits'(SINE_TABLE_DEPTH)
                                                               : idx_full[IdxBits-1:0];

    assign q_range  = s_tdata;
    assign q_ok     = s_tuser[0];
    assign q_check  = s_tuser[0] && checked;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== hw/rtl/lhg_queue.sv =====
// Short FIFO between the front end and the back end.
module lhg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rd_data
);
    localparam int PtrBits = $clog2(DEPTH);
    localparam int CntBits = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   slot_reg [DEPTH];
    logic [PtrBits-1:0] wr_ptr_reg;
    logic [PtrBits-1:0] wr_ptr_next;
    logic [PtrBits-1:0] rd_ptr_reg;
    logic [PtrBits-1:0] rd_ptr_next;
    logic [CntBits-1:0] count_reg;
    logic [CntBits-1:0] count_next;

    assign full    = (count_reg == CntBits'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/lhg_back.sv =====
// Back end: sine lookup, height test and output register.
module lhg_back #(
    parameter int RANGE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [15:0]                           height_limit_mm,
    input  logic                                  q_empty,
    output logic                                  pop,
    input  logic [15:0]                           q_range,
    input  logic                                  q_ok,
    input  logic                                  q_check,
    input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] q_idx,
    input  logic [15:0]                           q_angle,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [31:0]                           m_tdata,
    output logic [0:0]                            m_tuser
);
    import lhg_pkg::*;

    localparam int ProdBits = RANGE_BITS + 17;
    localparam int CmpBits  = (ProdBits > 32) ? ProdBits : 32;

    logic [16:0]           sine_rom [SINE_TABLE_DEPTH+1];

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [16:0]           s1_sine_reg;
    logic [15:0]           s1_range_reg;
    logic                  s1_ok_reg;
    logic                  s1_check_reg;
    logic [15:0]           s1_angle_reg;

    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [15:0]           m_range_reg;
    logic                  m_ok_reg;
    logic [15:0]           m_angle_reg;

    logic                  out_adv;
    logic                  s1_adv;
    logic [RANGE_BITS-1:0] rtest;
    logic [ProdBits-1:0]   prod;
    logic [CmpBits-1:0]    limit_cmp;
    logic                  too_high;

    generate
        for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
            localparam logic [63:0] XQ30 = (HALF_PI_Q30 * k) / SINE_TABLE_DEPTH;
            assign sine_rom[k] = series_sine(XQ30);
        end
    endgenerate

    assign out_adv = !m_valid_reg || m_tready;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign pop     = !q_empty && s1_adv;

    assign s1_valid_next = s1_adv ? !q_empty : s1_valid_reg;
    assign m_valid_next  = out_adv ? s1_valid_reg : m_valid_reg;

    assign rtest     = RANGE_BITS'(s1_range_reg);
    assign prod      = ProdBits'(rtest) * ProdBits'(s1_sine_reg);
    assign limit_cmp = CmpBits'({height_limit_mm, 16'd0});
    assign too_high  = s1_check_reg && (CmpBits'(prod) >= limit_cmp);

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_sine_reg  <= sine_rom[q_idx];
            s1_range_reg <= q_range;
            s1_ok_reg    <= q_ok;
            s1_check_reg <= q_check;
            s1_angle_reg <= q_angle;
        end
        if (out_adv && s1_valid_reg) begin
            m_range_reg <= s1_range_reg;
            m_ok_reg    <= s1_ok_reg && !too_high;
            m_angle_reg <= s1_angle_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_angle_reg, m_range_reg};
    assign m_tuser  = m_ok_reg;

endmodule

// ===== hw/rtl/lidar_height_gate_unit.sv =====
// Top level of the lidar height gate.
// Samples pass a four-deep FIFO between front and back end, the sine stage register
// and the output register. Throughput: one sample per cycle while m_tready is high;
// the sine table read and the range-by-sine multiply each take one pipeline stage.
// Reset (aresetn low, synchronous) clears the beam angle, the FIFO, the pipeline
// valid bits and loads the registers with their reset values; no clearing pass.
module lidar_height_gate_unit #(
    parameter int RANGE_BITS       = 16,
    parameter int ANGLE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // range_mm
    input  logic [1:0]  s_tuser,   // range_ok, scan_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // range_out_mm, beam_angle
    output logic [0:0]  m_tuser,   // range_out_ok
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lhg_pkg::*;

    localparam int IdxBits    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int EntryBits  = 16 + 1 + 1 + IdxBits + 16;
    localparam int QueueDepth = 4;

    cfg_t                 cfg;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;
    logic [15:0]          f_range;
    logic                 f_ok;
    logic                 f_check;
    logic [IdxBits-1:0]   f_idx;
    logic [15:0]          f_angle;
    logic [15:0]          b_range;
    logic                 b_ok;
    logic                 b_check;
    logic [IdxBits-1:0]   b_idx;
    logic [15:0]          b_angle;
    logic [EntryBits-1:0] wr_entry;
    logic [EntryBits-1:0] rd_entry;

    lhg_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lhg_front #(
        .ANGLE_BITS       (ANGLE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .q_range  (f_range),
        .q_ok     (f_ok),
        .q_check  (f_check),
        .q_idx    (f_idx),
        .q_angle  (f_angle)
    );

    assign wr_entry = {f_angle, f_idx, f_check, f_ok, f_range};
    assign {b_angle, b_idx, b_check, b_ok, b_range} = rd_entry;

    lhg_queue #(
        .WIDTH (EntryBits),
        .DEPTH (QueueDepth)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (wr_entry),
        .full    (q_full),
        .pop     (pop),
        .empty   (q_empty),
        .rd_data (rd_entry)
    );

    lhg_back #(
        .RANGE_BITS       (RANGE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .height_limit_mm (cfg.height_limit_mm),
        .q_empty         (q_empty),
        .pop             (pop),
        .q_range         (b_range),
        .q_ok            (b_ok),
        .q_check         (b_check),
        .q_idx           (b_idx),
        .q_angle         (b_angle),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

endmodule

// ===== hw/rtl/lhg_checker.sv =====
// Port-level checker for the lidar height gate, bound to the top level.
`include "lidar_height_gate_unit_assert.svh"

module lhg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
    import lhg_pkg::*;

    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic       in_xfer;
    logic       out_xfer;
    logic       cfg_wr_height;
    logic       cfg_rd_height;

    assign in_xfer       = s_tvalid && s_tready;
    assign out_xfer      = m_tvalid && m_tready;
    assign cfg_wr_height = psel && penable && pwrite && pready
                           && (paddr[3:2] == REG_HEIGHT_LIMIT);
    assign cfg_rd_height = psel && !pwrite && (paddr[3:2] == REG_HEIGHT_LIMIT);

    always_comb begin
        pending_next = pending_reg;
        if (in_xfer && !out_xfer) begin
            pending_next = pending_reg + 8'd1;
        end else if (out_xfer && !in_xfer) begin
            pending_next = pending_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 8'd0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    `LHG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result transaction changed while stalled")
    `LHG_ASSERT_IMPLY(a_no_extra_result, aclk, aresetn, m_tvalid, pending_reg != 8'd0, "result shown with no sample outstanding")
    `LHG_ASSERT_NEXT(a_reset_state, aclk, 1'b1, !aresetn, s_tready && !m_tvalid, "block not empty after reset")
    `LHG_ASSERT_NEXT(a_height_readback, aclk, aresetn, cfg_wr_height, !cfg_rd_height || (prdata[15:0] == $past(pwdata[15:0])), "height limit readback mismatch")

endmodule

bind lidar_height_gate_unit lhg_checker u_lhg_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the lidar height gate: directed and random beams vs. a local model.
module tb;
    import lhg_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 240;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_BEAMS = 1380;
    localparam int PHASES       = 8;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        range_ok;
        logic [15:0] beam_angle;
    } beam_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_COMB} rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // range_mm
    logic [1:0]  s_tuser;   // range_ok, scan_start
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // range_out_mm, beam_angle
    logic [0:0]  m_tuser;   // range_out_ok
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lidar_height_gate_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    cfg_t        gate_cfg;
    logic [15:0] next_angle;
    logic [16:0] quarter_sine [0:256];
    beam_t       pending_beams [$];
    int          err_count;
    int          beams_checked;
    int          cycle_count;
    int          burst_left;
    bit          sender_gaps_on;
    int          hold_requests;
    int          holds_served;

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [16:0] taylor_sine_q16(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        int          n;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (n = 3; n <= 15; n += 2) begin
            term = ((term * x2) >> 30) / (64'(n - 1) * 64'(n));
            if (n % 4 == 3) begin
                acc = (acc >= term) ? acc - term : 64'd0;
            end else begin
                acc = acc + term;
            end
        end
        acc = (acc + 64'd8192) >> 14;
        return (acc > 64'd65536) ? 17'd65536 : acc[16:0];
    endfunction

    task automatic build_sine_table();
        int k;
        for (k = 0; k <= 256; k++) begin
            quarter_sine[k] = taylor_sine_q16((HALF_PI_Q30 * 64'(k)) / 64'd256);
        end
    endtask

    // Predict one beam and advance the angle.
    function automatic beam_t gate_beam(input logic [15:0] rng, input logic ok,
                                        input logic scan_first);
        beam_t       res;
        logic [15:0] angle;
        logic [63:0] p;
        logic [63:0] idx;
        bit          checked;
        angle = scan_first ? gate_cfg.start_angle : next_angle;
        res.range_mm   = rng;
        res.beam_angle = angle;
        res.range_ok   = ok;
        if (ok) begin
            if (gate_cfg.side_select == 1'b0) begin
                checked = angle < 16'd32768;
                p = 64'(angle);
            end else begin
                checked = angle > 16'd32768;
                p = 64'(angle) - 64'd32768;
            end
            if (p > 64'd16384) p = 64'd32768 - p;
            idx = (p * 64'd256 + 64'd8192) / 64'd16384;
            if (idx > 64'd256) idx = 64'd256;
            if (checked && (64'(rng) * 64'(quarter_sine[idx]) >=
                            (64'(gate_cfg.height_limit_mm) << 16))) begin
                res.range_ok = 1'b0;
            end
        end
        next_angle = angle + gate_cfg.angle_step;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH beam %0d %s: expected %0d got %0d", beams_checked, what, want, got);
        err_count++;
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("lidar_height_gate_unit verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin : check_beam
        beam_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_beams.size() == 0) begin
                report_mismatch("unexpected transaction", 32'd0, m_tdata);
            end else begin
                want = pending_beams.pop_front();
                if (m_tdata[15:0] !== want.range_mm)
                    report_mismatch("range_out_mm", want.range_mm, m_tdata[15:0]);
                if (m_tuser[0] !== want.range_ok)
                    report_mismatch("range_out_ok", want.range_ok, m_tuser[0]);
                if (m_tdata[31:16] !== want.beam_angle)
                    report_mismatch("beam_angle", want.beam_angle, m_tdata[31:16]);
            end
            beams_checked++;
        end
    end

    initial begin : output_receiver
        rx_mode_t mode;
        int       mode_left;
        int       held;
        m_tready  = 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_served) begin
                m_tready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(negedge aclk);
                holds_served++;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_tready <= ((cycle_count % 5) < 2);
                endcase
            end
        end
    end

    // Enter and leave just after a falling edge.
    task automatic send_beam(input logic [15:0] rng, input logic ok, input logic scan_first);
        int gap;
        if (burst_left == 0) begin
            if (sender_gaps_on) begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= rng;
        s_tuser  <= {scan_first, ok};
        do @(posedge aclk); while (!s_tready);
        pending_beams.push_back(gate_beam(rng, ok, scan_first));
        @(negedge aclk);
    endtask

    task automatic drain_beams();
        s_tvalid <= 1'b0;
        while (pending_beams.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_HEIGHT_LIMIT: gate_cfg.height_limit_mm = value[15:0];
            REG_START_ANGLE:  gate_cfg.start_angle     = value[15:0];
            REG_ANGLE_STEP:   gate_cfg.angle_step      = value[15:0];
            default:          gate_cfg.side_select     = value[0];
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_gate_config(input logic [15:0] limit, input logic [15:0] start,
                                   input logic [15:0] step, input logic side);
        drain_beams();
        apb_write(REG_HEIGHT_LIMIT, {16'd0, limit});
        apb_write(REG_START_ANGLE,  {16'd0, start});
        apb_write(REG_ANGLE_STEP,   {16'd0, step});
        apb_write(REG_SIDE_SELECT,  {31'd0, side});
        @(negedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_beam(16'hFFFF, 1'b1, 1'b1);
        send_beam(16'd2000, 1'b1, 1'b0);
    endtask

    task automatic test_zero_limit();
        set_gate_config(16'd0, 16'd0, 16'd0, 1'b0);
        send_beam(16'd0, 1'b1, 1'b1);
        send_beam(16'hFFFF, 1'b1, 1'b0);
        set_gate_config(16'd0, 16'd0, 16'd0, 1'b1);
        send_beam(16'd100, 1'b1, 1'b1);
        set_gate_config(16'd0, 16'd49152, 16'd0, 1'b1);
        send_beam(16'd1, 1'b1, 1'b1);
    endtask

    task automatic test_boundary_angles();
        set_gate_config(16'd0, 16'd32768, 16'd0, 1'b0);
        send_beam(16'd500, 1'b1, 1'b1);
        set_gate_config(16'd0, 16'd32768, 16'd0, 1'b1);
        send_beam(16'd500, 1'b1, 1'b1);
        set_gate_config(16'hFFFF, 16'd16384, 16'd0, 1'b0);
        send_beam(16'hFFFF, 1'b1, 1'b1);
        send_beam(16'hFFFE, 1'b1, 1'b0);
    endtask

    task automatic test_invalid_input();
        set_gate_config(16'd0, 16'd100, 16'd1000, 1'b0);
        send_beam(16'd1234, 1'b0, 1'b1);
        send_beam(16'hFFFF, 1'b0, 1'b0);
        send_beam(16'd1, 1'b1, 1'b0);
    endtask

    task automatic test_step_extremes();
        int i;
        set_gate_config(16'd1500, 16'hFFFF, 16'h7FFF, 1'b0);
        for (i = 0; i < 4; i++) send_beam(16'd40000, 1'b1, (i == 0));
        set_gate_config(16'd1500, 16'd0, 16'h8000, 1'b1);
        for (i = 0; i < 3; i++) send_beam(16'd40000, 1'b1, (i == 0));
    endtask

    function automatic logic [15:0] pick_range(input logic [15:0] limit);
        logic [31:0] r;
        case ($urandom_range(0, 4))
            0:       r = $urandom_range(0, 65535);
            1:       r = 32'(limit) + $urandom_range(0, 32'(limit));
            2:       r = $urandom_range(0, 1) ? 32'hFFFF : 32'd0;
            3:       r = $urandom_range(0, 4095);
            default: r = 32'(limit) + $urandom_range(0, 32'(limit) / 4 + 1);
        endcase
        return (r > 32'hFFFF) ? 16'hFFFF : r[15:0];
    endfunction

    task automatic test_random_scans();
        int          phase;
        int          sent;
        int          scan_len;
        int          i;
        logic [15:0] limit;
        logic [15:0] start;
        logic [15:0] step;
        logic        scan_first;
        for (phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       limit = 16'hFFFF;
                1:       limit = 16'd0;
                2:       limit = $urandom_range(100, 3000);
                default: limit = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 4))
                0:       start = 16'hFFFF;
                1:       start = 16'd16384;
                2:       start = 16'd32768;
                3:       start = 16'd0;
                default: start = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 4))
                0:       step = 16'h8000;
                1:       step = 16'h7FFF;
                2:       step = 16'd0;
                3:       step = $urandom_range(0, 1) ? 16'($urandom_range(1, 600))
                                                     : -16'($urandom_range(1, 600));
                default: step = $urandom_range(0, 65535);
            endcase
            if (phase == 0) begin
                limit = 16'hFFFF;
                start = 16'hFFFF;
                step  = 16'h8000;
            end else if (phase == 1) begin
                limit = 16'd0;
                start = 16'd0;
                step  = 16'h7FFF;
            end
            set_gate_config(limit, start, step, phase[0]);
            sender_gaps_on = (phase != 3);
            sent = 0;
            while (sent < RANDOM_BEAMS / PHASES) begin
                scan_len = $urandom_range(1, 48);
                for (i = 0; i < scan_len && sent < RANDOM_BEAMS / PHASES; i++) begin
                    scan_first = (i == 0);
                    // break the scan now and then with a stray or missing start flag
                    if ($urandom_range(0, 19) == 0) scan_first = ~scan_first;
                    send_beam(pick_range(limit), ($urandom_range(0, 9) != 0), scan_first);
                    sent++;
                end
            end
        end
        sender_gaps_on = 1'b1;
    endtask

    task automatic test_output_hold();
        int i;
        set_gate_config(16'd800, 16'd1000, 16'd300, 1'b0);
        sender_gaps_on = 1'b0;
        hold_requests++;
        for (i = 0; i < 40; i++) send_beam(pick_range(16'd800), 1'b1, (i == 0));
        sender_gaps_on = 1'b1;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 16'd0;
        s_tuser        = 2'd0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = 4'd0;
        pwdata         = 32'd0;
        err_count      = 0;
        beams_checked  = 0;
        cycle_count    = 0;
        burst_left     = 0;
        sender_gaps_on = 1'b1;
        hold_requests  = 0;
        holds_served   = 0;
        next_angle     = 16'd0;
        gate_cfg.height_limit_mm = HEIGHT_LIMIT_RESET;
        gate_cfg.start_angle     = 16'd0;
        gate_cfg.angle_step      = 16'sd0;
        gate_cfg.side_select     = 1'b0;
        build_sine_table();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_zero_limit();
        test_boundary_angles();
        test_invalid_input();
        test_step_extremes();
        test_output_hold();
        test_random_scans();
        test_output_hold();

        drain_beams();
        if (err_count == 0) begin
            $display("lidar_height_gate_unit verification clean");
        end else begin
            $display("lidar_height_gate_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lhg_pkg.sv
hw/rtl/lhg_cfg.sv
hw/rtl/lhg_front.sv
hw/rtl/lhg_queue.sv
hw/rtl/lhg_back.sv
hw/rtl/lidar_height_gate_unit.sv
hw/rtl/lhg_checker.sv
tb/tb.sv
